// ----- rtl/lrc_pkg.sv -----
package lrc_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned VAL_W       = 32;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SELECT,
    ST_COMMIT
  } lrc_state_e;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] req_key;
    logic [VAL_W-1:0] req_value;
    logic             capture;
  } lrc_cell_ctrl_t;

endpackage

// ----- rtl/lrc_if.sv -----
interface lrc_in_if;
  import lrc_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [KEY_W-1:0] request_key;
  logic [VAL_W-1:0] store_value;

  modport source (output valid, output func, output request_key, output store_value,
                  input ready);
  modport sink (input valid, input func, input request_key, input store_value,
                output ready);
endinterface

interface lrc_out_if;
  import lrc_pkg::*;

  logic             valid;
  logic             ready;
  logic             hit;
  logic [VAL_W-1:0] found_value;

  modport source (output valid, output hit, output found_value, input ready);
  modport sink (input valid, input hit, input found_value, output ready);
endinterface

// ----- rtl/lrc_cell.sv -----
module lrc_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lrc_pkg::lrc_cell_ctrl_t ctrl_i,
  input  logic                   load_i,
  input  logic [lrc_pkg::KEY_W-1:0] key_i,
  input  logic [lrc_pkg::VAL_W-1:0] value_i,
  output logic [lrc_pkg::KEY_W-1:0] key_o,
  output logic [lrc_pkg::VAL_W-1:0] value_o,
  output logic                   match_o
);
  import lrc_pkg::*;

  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;
  logic             match_q;
  logic             match_d;
  logic             empty;
  logic             key_eq;

  // Empty entries are marked by a zero value, so only the value needs a reset.
  assign empty  = (value_q == '0);
  assign key_eq = (key_q == ctrl_i.req_key);

  always_comb begin
    if (ctrl_i.func == FUNC_UPDATE) begin
      match_d = empty || (key_eq && (value_q == ctrl_i.req_value));
    end else begin
      match_d = !empty && key_eq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      key_q <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else if (load_i) begin
      value_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      match_q <= match_d;
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign match_o = match_q;

endmodule

// ----- rtl/lru_rate_cache.sv -----
// A result is offered after its request passes the match, select and commit
// states: the cell row compares, the first matching position is isolated, then
// the row shifts toward the back. A request is taken only in the idle state.
// A waiting result does not block the next request from being accepted.
// Reset: asynchronous, active low; every entry is empty after reset.
module lru_rate_cache #(
  parameter int unsigned ENTRIES = lrc_pkg::ENTRIES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lrc_in_if.sink    req_i,
  lrc_out_if.source rsp_o
);
  import lrc_pkg::*;

  lrc_state_e state_q, state_d;

  logic             func_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] sel_q, sel_d;
  logic [ENTRIES-1:0] load_mask;
  logic               change_q, change_d;
  logic               hit_q, hit_d;

  logic [KEY_W-1:0] cell_key [ENTRIES];
  logic [VAL_W-1:0] cell_value [ENTRIES];

  logic [KEY_W-1:0] sel_key;
  logic [VAL_W-1:0] sel_value;
  logic [KEY_W-1:0] front_key;
  logic [VAL_W-1:0] front_value;

  logic accept;
  logic capture;
  logic select_en;
  logic commit;

  logic             out_valid_q;
  logic             out_hit_q;
  logic [VAL_W-1:0] out_value_q;

  lrc_cell_ctrl_t cell_ctrl;

  localparam logic [ENTRIES-1:0] OneLsb = {{(ENTRIES-1){1'b0}}, 1'b1};
  localparam logic [ENTRIES-1:0] OneMsb = {1'b1, {(ENTRIES-1){1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    capture   = 1'b0;
    select_en = 1'b0;
    commit    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: begin
        capture = 1'b1;
        state_d = ST_SELECT;
      end
      ST_SELECT: begin
        select_en = 1'b1;
        state_d   = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= req_i.func;
      key_q   <= req_i.request_key;
      value_q <= req_i.store_value;
    end
  end

  assign cell_ctrl.func      = func_q;
  assign cell_ctrl.req_key   = key_q;
  assign cell_ctrl.req_value = value_q;
  assign cell_ctrl.capture   = capture;

  // The first matching position in recency order is isolated with a two's
  // complement trick. An update without a match replaces the last position.
  always_comb begin
    logic [ENTRIES-1:0] first;
    logic               any;
    first = match & (~match + OneLsb);
    any   = |match;
    hit_d = 1'b0;
    if (func_q == FUNC_UPDATE) begin
      change_d = 1'b1;
      sel_d    = any ? first : OneMsb;
    end else begin
      change_d = any;
      hit_d    = any;
      sel_d    = first;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q    <= '0;
      change_q <= 1'b0;
      hit_q    <= 1'b0;
    end else if (select_en) begin
      sel_q    <= sel_d;
      change_q <= change_d;
      hit_q    <= hit_d;
    end
  end

  always_comb begin
    sel_key   = '0;
    sel_value = '0;
    for (int unsigned p = 0; p < ENTRIES; p++) begin
      sel_key   = sel_key | (cell_key[p] & {KEY_W{sel_q[p]}});
      sel_value = sel_value | (cell_value[p] & {VAL_W{sel_q[p]}});
    end
  end

  assign front_key   = (func_q == FUNC_UPDATE) ? key_q : sel_key;
  assign front_value = (func_q == FUNC_UPDATE) ? value_q : sel_value;

  // Every position up to and including the chosen one moves back by one.
  assign load_mask = (commit && change_q) ? (sel_q | (sel_q - OneLsb)) : '0;

  for (genvar p = 0; p < ENTRIES; p++) begin : g_cell
    logic [KEY_W-1:0] nbr_key;
    logic [VAL_W-1:0] nbr_value;

    if (p == 0) begin : g_front
      assign nbr_key   = front_key;
      assign nbr_value = front_value;
    end else begin : g_chain
      assign nbr_key   = cell_key[p-1];
      assign nbr_value = cell_value[p-1];
    end

    lrc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .load_i  (load_mask[p]),
      .key_i   (nbr_key),
      .value_i (nbr_value),
      .key_o   (cell_key[p]),
      .value_o (cell_value[p]),
      .match_o (match[p])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_hit_q   <= hit_q;
      out_value_q <= hit_q ? sel_value : '0;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.found_value = out_value_q;

endmodule

// ----- tb/lru_rate_cache_tb.sv -----
module lru_rate_cache_tb;
  import lrc_pkg::*;

  localparam int unsigned ENTRIES     = ENTRIES_DEF;
  localparam int unsigned IDX_W       = $clog2(ENTRIES);
  localparam int unsigned KEY_POOL    = 22;
  localparam int unsigned RATE_POOL   = 8;
  localparam int unsigned PHASE_ITEMS = 512;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned MAX_REPORTS = 50;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } rate_req_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
  } rate_rsp_t;

  logic clk;
  logic rst_n;

  lrc_in_if  req_if ();
  lrc_out_if rsp_if ();

  lru_rate_cache #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  logic [KEY_W-1:0] cached_key [ENTRIES];
  logic [VAL_W-1:0] cached_rate[ENTRIES];
  logic [IDX_W-1:0] recency    [ENTRIES];

  rate_req_t pend_q[$];
  rate_rsp_t rate_rsp_q[$];

  logic [KEY_W-1:0] key_pool [KEY_POOL];
  logic [VAL_W-1:0] rate_pool[RATE_POOL];

  int unsigned n_issued;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_lookups;
  int unsigned n_hits;
  int unsigned n_updates;
  int unsigned n_errors;
  int unsigned stall_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        req_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void move_to_front(input int unsigned pos);
    logic [IDX_W-1:0] slot;
    slot = recency[pos];
    for (int unsigned p = pos; p > 0; p--) recency[p] = recency[p-1];
    recency[0] = slot;
  endfunction

  function automatic rate_rsp_t access_cache(input rate_req_t r);
    rate_rsp_t        res;
    int unsigned      chosen;
    logic [IDX_W-1:0] slot;
    res = '0;
    if (r.func == FUNC_LOOKUP) begin
      for (int unsigned pos = 0; pos < ENTRIES; pos++) begin
        slot = recency[pos];
        if (cached_rate[slot] != '0 && cached_key[slot] == r.key) begin
          res.hit   = 1'b1;
          res.value = cached_rate[slot];
          move_to_front(pos);
          break;
        end
      end
    end else begin
      chosen = ENTRIES - 1;
      for (int unsigned pos = 0; pos < ENTRIES; pos++) begin
        slot = recency[pos];
        if (cached_rate[slot] == '0 ||
            (cached_rate[slot] == r.value && cached_key[slot] == r.key)) begin
          chosen = pos;
          break;
        end
      end
      slot              = recency[chosen];
      cached_key[slot]  = r.key;
      cached_rate[slot] = r.value;
      move_to_front(chosen);
    end
    return res;
  endfunction

  task automatic push_req(input logic func, input logic [KEY_W-1:0] key,
                          input logic [VAL_W-1:0] value);
    rate_req_t r;
    r.func  = func;
    r.key   = key;
    r.value = value;
    pend_q.push_back(r);
    n_issued++;
  endtask

  task automatic queue_random(input int unsigned count);
    logic             func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    int unsigned      roll;
    repeat (count) begin
      func = ($urandom_range(99) < 45) ? FUNC_LOOKUP : FUNC_UPDATE;
      roll = $urandom_range(99);
      key  = (roll < 94) ? key_pool[$urandom_range(KEY_POOL-1)] : KEY_W'($urandom);
      roll = $urandom_range(99);
      if (roll < 5) begin
        value = '0;
      end else if (roll < 70) begin
        value = rate_pool[$urandom_range(RATE_POOL-1)];
      end else begin
        value = VAL_W'($urandom);
      end
      push_req(func, key, value);
    end
  endtask

  task automatic drain();
    do @(negedge clk); while (n_accepted != n_issued || rate_rsp_q.size() != 0);
    @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queue_random(PHASE_ITEMS / 2);
    drain();
    queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
    drain();
  endtask

  always @(negedge clk) begin : driver_b
    rate_req_t r;
    if (rst_n) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!req_if.valid || req_taken) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          r = pend_q.pop_front();
          req_if.valid       <= 1'b1;
          req_if.func        <= r.func;
          req_if.request_key <= r.key;
          req_if.store_value <= r.value;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor_b
    rate_req_t r;
    rate_rsp_t want;
    if (rst_n) begin
      req_taken <= req_if.valid && req_if.ready;
      if (rsp_if.valid && rsp_if.ready) begin
        n_checked++;
        if (rate_rsp_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: unexpected result transaction: hit %0b value %h", $time,
                     rsp_if.hit, rsp_if.found_value);
        end else begin
          want = rate_rsp_q.pop_front();
          if (rsp_if.hit !== want.hit) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: hit mismatch: expected %0b, actual %0b", $time,
                       want.hit, rsp_if.hit);
          end
          if (rsp_if.found_value !== want.value) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: found_value mismatch: expected %h, actual %h", $time,
                       want.value, rsp_if.found_value);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        r.func  = req_if.func;
        r.key   = req_if.request_key;
        r.value = req_if.store_value;
        want    = access_cache(r);
        rate_rsp_q.push_back(want);
        n_accepted++;
        if (r.func == FUNC_LOOKUP) begin
          n_lookups++;
          if (want.hit) n_hits++;
        end else begin
          n_updates++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog_b
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.func        = FUNC_LOOKUP;
    req_if.request_key = '0;
    req_if.store_value = '0;
    rsp_if.ready       = 1'b0;
    req_taken          = 1'b0;
    n_issued           = 0;
    n_accepted         = 0;
    n_checked          = 0;
    n_lookups          = 0;
    n_hits             = 0;
    n_updates          = 0;
    n_errors           = 0;
    stall_cycles       = 0;
    send_idle_pct      = 16;
    recv_idle_pct      = 78;
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      cached_key[i]  = '0;
      cached_rate[i] = '0;
      recency[i]     = IDX_W'(i);
    end
    for (int unsigned i = 0; i < KEY_POOL; i++) key_pool[i] = KEY_W'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int unsigned i = 0; i < RATE_POOL; i++) rate_pool[i] = VAL_W'($urandom) | 1;
    rate_pool[0] = '1;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // An empty cache must miss even on key zero, whose stored value is zero.
    push_req(FUNC_LOOKUP, '0, '1);
    push_req(FUNC_UPDATE, '0, VAL_W'(1));
    push_req(FUNC_LOOKUP, '0, '0);
    push_req(FUNC_UPDATE, '1, '1);
    push_req(FUNC_LOOKUP, '1, '0);
    // A zero store value leaves the written entry empty.
    push_req(FUNC_UPDATE, KEY_W'(5), '0);
    push_req(FUNC_LOOKUP, KEY_W'(5), '0);
    // Two entries with the same key: the more recent one wins.
    push_req(FUNC_UPDATE, KEY_W'(7), VAL_W'(10));
    push_req(FUNC_UPDATE, KEY_W'(7), VAL_W'(20));
    push_req(FUNC_LOOKUP, KEY_W'(7), '0);
    push_req(FUNC_UPDATE, KEY_W'(7), VAL_W'(10));
    push_req(FUNC_LOOKUP, KEY_W'(7), '0);
    push_req(FUNC_LOOKUP, KEY_W'(9), '0);
    push_req(FUNC_LOOKUP, '0, '0);
    // Fill every entry so the least recent one gets evicted.
    for (int unsigned i = 0; i < ENTRIES + 2; i++)
      push_req(FUNC_UPDATE, KEY_W'(32'h100 + i), VAL_W'(32'h8000_0000 + i));
    push_req(FUNC_LOOKUP, '1, '0);
    push_req(FUNC_LOOKUP, KEY_W'(32'h100 + ENTRIES + 1), '0);
    drain();

    run_phase(16, 78);
    run_phase(78, 16);
    run_phase(0, 0);

    repeat (20) @(posedge clk);
    $display("Ran %0d requests: %0d lookups with %0d hits, %0d updates; %0d results checked.",
             n_accepted, n_lookups, n_hits, n_updates, n_checked);
    $display("Throttling covered slow receiver, slow sender and back-to-back traffic.");
    if (n_errors == 0 && rate_rsp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
